// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the rtl checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/tpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tpt_pkg
// shared types and constants of the text position tracker
// ----------------------------------------------------------------------------
package tpt_pkg;

   localparam int FIELD_W          = 24;
   localparam int POS_BITS_DEFAULT = 24;
   localparam int UNIT_W           = 2;
   localparam int RSP_DATA_W       = 4 * FIELD_W;

   typedef enum logic [UNIT_W-1:0] {
      UNIT_UTF8      = 2'd0,
      UNIT_UTF16     = 2'd1,
      UNIT_CODEPOINT = 2'd2
   } unit_type;

   localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_UTF16;

   localparam logic [7:0] NEWLINE    = 8'h0A;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;

   typedef struct packed {
      logic               at_boundary;
      logic [FIELD_W-1:0] char_column;
      logic [FIELD_W-1:0] line_bytes;
      logic [FIELD_W-1:0] line_number;
      logic [FIELD_W-1:0] byte_offset;
   } rsp_beat_type;

endpackage

// ----- rtl/core/text_position_tracker.sv -----
// ----------------------------------------------------------------------------
// text_position_tracker
// an accepted input beat is offered as its result beat in the cycle after it is taken
// throughput: one byte per cycle while rsp_tready is high, set by the single result register
// req_tready stays high while the result register is empty or being drained
// reset clears all counters and the result valid, column unit returns to utf-16
// ----------------------------------------------------------------------------
module text_position_tracker #(
   parameter int POS_BITS = tpt_pkg::POS_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // data_byte
   input  logic                              req_tlast,   // end_of_text
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // byte_offset, line_number, line_bytes, char_column
   output logic [tpt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser,   // at_boundary
   input  logic                              csr_wr_en,
   input  logic [tpt_pkg::UNIT_W-1:0]        csr_wr_data  // unit_encoding
);

   logic [tpt_pkg::UNIT_W-1:0] unit_ff;
   logic                       req_accept;
   tpt_pkg::rsp_beat_type      next_beat;
   tpt_pkg::rsp_beat_type      rsp_beat;

   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= tpt_pkg::UNIT_RESET;
      end else if (csr_wr_en) begin
         unit_ff <= csr_wr_data;
      end
   end

   tpt_update #(
      .POS_BITS (POS_BITS)
   ) u_update (
      .clock       (clock),
      .reset       (reset),
      .unit_sel    (unit_ff),
      .item_valid  (req_accept),
      .data_byte   (req_tdata),
      .end_of_text (req_tlast),
      .beat        (next_beat)
   );

   tpt_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_beat   (next_beat),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_beat  (rsp_beat)
   );

   assign rsp_tdata = {rsp_beat.char_column, rsp_beat.line_bytes,
                       rsp_beat.line_number, rsp_beat.byte_offset};
   assign rsp_tuser = rsp_beat.at_boundary;

endmodule

// ----- rtl/core/tpt_update.sv -----
// ----------------------------------------------------------------------------
// tpt_update
// position counters, utf-8 sequence tracking and result formation per byte
// ----------------------------------------------------------------------------
module tpt_update #(
   parameter int POS_BITS = tpt_pkg::POS_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tpt_pkg::UNIT_W-1:0]  unit_sel,
   input  logic                        item_valid,
   input  logic [7:0]                  data_byte,
   input  logic                        end_of_text,
   output tpt_pkg::rsp_beat_type       beat
);

   logic [POS_BITS-1:0] offset_ff, offset_in;
   logic [POS_BITS-1:0] line_ff, line_in;
   logic [POS_BITS-1:0] column_ff, column_in;
   logic [POS_BITS-1:0] units_ff, units_in;
   logic [1:0]          left_ff, left_in;
   logic [1:0]          partial_ff, partial_in;
   logic [1:0]          seq_units_ff, seq_units_in;

   function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
                                                   input logic [2:0] b);
      logic [POS_BITS:0] s;
      s = {1'b0, a} + (POS_BITS + 1)'(b);
      return s[POS_BITS] ? {POS_BITS{1'b1}} : s[POS_BITS-1:0];
   endfunction

   function automatic logic [tpt_pkg::FIELD_W-1:0] to_field(input logic [POS_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[tpt_pkg::FIELD_W-1:0];
   endfunction

   // result reflects the position before this byte
   always_comb begin
      beat.byte_offset = to_field(offset_ff);
      beat.line_number = to_field(line_ff);
      beat.line_bytes  = to_field(column_ff);
      beat.char_column = to_field(sat_add(units_ff, {1'b0, partial_ff}));
      beat.at_boundary = (left_ff == 2'd0);
   end

   always_comb begin
      logic [2:0] add;
      offset_in    = offset_ff;
      line_in      = line_ff;
      column_in    = column_ff;
      units_in     = units_ff;
      left_in      = left_ff;
      partial_in   = partial_ff;
      seq_units_in = seq_units_ff;
      add          = 3'd1;
      if (item_valid) begin
         if (end_of_text) begin
            offset_in    = '0;
            line_in      = '0;
            column_in    = '0;
            units_in     = '0;
            left_in      = 2'd0;
            partial_in   = 2'd0;
            seq_units_in = 2'd0;
         end else begin
            offset_in = sat_add(offset_ff, 3'd1);
            if (data_byte == tpt_pkg::NEWLINE) begin
               line_in      = sat_add(line_ff, 3'd1);
               column_in    = '0;
               units_in     = '0;
               left_in      = 2'd0;
               partial_in   = 2'd0;
               seq_units_in = 2'd0;
            end else begin
               column_in = sat_add(column_ff, 3'd1);
               if (left_ff != 2'd0) begin
                  left_in = left_ff - 2'd1;
                  if (left_ff == 2'd1) begin
                     case (unit_sel)
                        tpt_pkg::UNIT_UTF8:      add = {1'b0, partial_ff} + 3'd1;
                        tpt_pkg::UNIT_CODEPOINT: add = 3'd1;
                        default:                 add = {1'b0, seq_units_ff};
                     endcase
                     units_in     = sat_add(units_ff, add);
                     partial_in   = 2'd0;
                     seq_units_in = 2'd0;
                  end else begin
                     partial_in = partial_ff + 2'd1;
                  end
               end else if ((data_byte & tpt_pkg::LEAD2_MASK) == tpt_pkg::LEAD2_CODE) begin
                  left_in      = 2'd1;
                  partial_in   = 2'd1;
                  seq_units_in = 2'd1;
               end else if ((data_byte & tpt_pkg::LEAD3_MASK) == tpt_pkg::LEAD3_CODE) begin
                  left_in      = 2'd2;
                  partial_in   = 2'd1;
                  seq_units_in = 2'd1;
               end else if ((data_byte & tpt_pkg::LEAD4_MASK) == tpt_pkg::LEAD4_CODE) begin
                  left_in      = 2'd3;
                  partial_in   = 2'd1;
                  seq_units_in = 2'd2;
               end else begin
                  units_in = sat_add(units_ff, 3'd1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         line_ff      <= '0;
         column_ff    <= '0;
         units_ff     <= '0;
         left_ff      <= 2'd0;
         partial_ff   <= 2'd0;
         seq_units_ff <= 2'd0;
      end else begin
         offset_ff    <= offset_in;
         line_ff      <= line_in;
         column_ff    <= column_in;
         units_ff     <= units_in;
         left_ff      <= left_in;
         partial_ff   <= partial_in;
         seq_units_ff <= seq_units_in;
      end
   end

endmodule

// ----- rtl/core/tpt_out_reg.sv -----
// ----------------------------------------------------------------------------
// tpt_out_reg
// result register between the position logic and the result channel
// ----------------------------------------------------------------------------
module tpt_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tpt_pkg::rsp_beat_type in_beat,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tpt_pkg::rsp_beat_type out_beat
);

   logic                  valid_ff, valid_in;
   tpt_pkg::rsp_beat_type beat_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = (in_valid && in_ready) || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         beat_ff <= in_beat;
      end
   end

endmodule

// ----- rtl/core/tpt_checker.sv -----
// ----------------------------------------------------------------------------
// tpt_checker
// port-level checks of the text position tracker, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpt_checker #(
   parameter int POS_BITS = tpt_pkg::POS_BITS_DEFAULT
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tpt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);

   localparam int FW = tpt_pkg::FIELD_W;

   // a held result beat stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // every accepted input beat shows up as a result beat in the next cycle
   `ASSERT_NEXT(a_rsp_follows, clock, reset, req_tvalid && req_tready, rsp_tvalid)

   // input side only stalls while a result beat is stuck
   `ASSERT_IMP(a_ready_rule, clock, reset, 1'b1, req_tready == (!rsp_tvalid || rsp_tready))

   // inside an open sequence at least the lead byte lies on this line
   `ASSERT_IMP(a_partial_col, clock, reset, (POS_BITS <= FW) && rsp_tvalid && !rsp_tuser,
      rsp_tdata[3*FW-1:2*FW] != '0)

endmodule

bind text_position_tracker tpt_checker #(
   .POS_BITS (POS_BITS)
) u_tpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- verif/tb_text_position_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_position_tracker
// streams document bytes and end markers into the text position tracker
// and checks every result beat against a position predictor, over all
// column units and with stalls on both sides
// ----------------------------------------------------------------------------
module tb_text_position_tracker;

   localparam logic [tpt_pkg::UNIT_W-1:0]  UNIT_SPARE = 2'd3;
   localparam logic [tpt_pkg::FIELD_W-1:0] POS_MAX    = {tpt_pkg::FIELD_W{1'b1}};

   class position_scoreboard;
      tpt_pkg::rsp_beat_type        expected_q[$];
      logic [tpt_pkg::UNIT_W-1:0]   unit;
      logic [tpt_pkg::FIELD_W-1:0]  offset_cnt, line_cnt, col_bytes, units_closed;
      logic [1:0]                   tail_left, tail_seen, seq_units;
      int unsigned                  failures, results_checked, bytes_seen, ends_seen;

      function new();
         unit = tpt_pkg::UNIT_RESET;
         clear_position();
         failures = 0;
         results_checked = 0;
         bytes_seen = 0;
         ends_seen = 0;
      endfunction

      function void clear_position();
         offset_cnt = '0;
         line_cnt = '0;
         col_bytes = '0;
         units_closed = '0;
         tail_left = '0;
         tail_seen = '0;
         seq_units = '0;
      endfunction

      function logic [tpt_pkg::FIELD_W-1:0] sat_add(logic [tpt_pkg::FIELD_W-1:0] a,
                                                    int unsigned n);
         logic [tpt_pkg::FIELD_W:0] s;
         s = {1'b0, a} + (tpt_pkg::FIELD_W + 1)'(n);
         return (s > POS_MAX) ? POS_MAX : s[tpt_pkg::FIELD_W-1:0];
      endfunction

      function void set_unit(logic [tpt_pkg::UNIT_W-1:0] u);
         unit = u;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_input(logic [7:0] b, logic eot);
         tpt_pkg::rsp_beat_type e;
         int unsigned           seq_len, add;
         e.byte_offset = offset_cnt;
         e.line_number = line_cnt;
         e.line_bytes  = col_bytes;
         e.char_column = sat_add(units_closed, tail_seen);
         e.at_boundary = (tail_left == 0);
         expected_q = {expected_q, e};
         if (eot) begin
            ends_seen++;
            clear_position();
            return;
         end
         bytes_seen++;
         offset_cnt = sat_add(offset_cnt, 1);
         if (b == tpt_pkg::NEWLINE) begin
            line_cnt = sat_add(line_cnt, 1);
            col_bytes = '0;
            units_closed = '0;
            tail_left = '0;
            tail_seen = '0;
            seq_units = '0;
            return;
         end
         col_bytes = sat_add(col_bytes, 1);
         // tail bytes other than a newline are skipped whatever their value
         if (tail_left != 0) begin
            tail_left--;
            if (tail_left == 0) begin
               if (unit == tpt_pkg::UNIT_UTF8) add = tail_seen + 1;
               else if (unit == tpt_pkg::UNIT_CODEPOINT) add = 1;
               else add = seq_units;
               units_closed = sat_add(units_closed, add);
               tail_seen = '0;
               seq_units = '0;
            end else begin
               tail_seen++;
            end
            return;
         end
         if ((b & tpt_pkg::LEAD2_MASK) == tpt_pkg::LEAD2_CODE) seq_len = 2;
         else if ((b & tpt_pkg::LEAD3_MASK) == tpt_pkg::LEAD3_CODE) seq_len = 3;
         else if ((b & tpt_pkg::LEAD4_MASK) == tpt_pkg::LEAD4_CODE) seq_len = 4;
         else seq_len = 1;
         if (seq_len == 1) begin
            units_closed = sat_add(units_closed, 1);
         end else begin
            tail_left = 2'(seq_len - 1);
            tail_seen = 2'd1;
            seq_units = (seq_len == 4) ? 2'd2 : 2'd1;
         end
      endfunction

      function void check_result(logic [tpt_pkg::RSP_DATA_W-1:0] data, logic boundary);
         tpt_pkg::rsp_beat_type got, e;
         got = tpt_pkg::rsp_beat_type'({boundary, data});
         results_checked++;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result beat: off=%0d line=%0d bcol=%0d ccol=%0d bnd=%0b",
                        got.byte_offset, got.line_number, got.line_bytes,
                        got.char_column, got.at_boundary);
            return;
         end
         e = expected_q.pop_front();
         if (got.byte_offset !== e.byte_offset || got.line_number !== e.line_number ||
             got.line_bytes !== e.line_bytes || got.char_column !== e.char_column ||
             got.at_boundary !== e.at_boundary) begin
            failures++;
            if (failures <= 10) begin
               $display("mismatch at result %0d: exp off=%0d line=%0d bcol=%0d ccol=%0d bnd=%0b",
                        results_checked, e.byte_offset, e.line_number, e.line_bytes,
                        e.char_column, e.at_boundary);
               $display("   got off=%0d line=%0d bcol=%0d ccol=%0d bnd=%0b",
                        got.byte_offset, got.line_number, got.line_bytes,
                        got.char_column, got.at_boundary);
            end
         end
      endfunction

      function void close_out();
         if (expected_q.size() != 0) begin
            $display("%0d result beats never arrived", expected_q.size());
            failures += expected_q.size();
         end
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [7:0]                        req_tdata = '0;
   logic                              req_tlast = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [tpt_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                              rsp_tuser;
   logic                              csr_wr_en = 1'b0;
   logic [tpt_pkg::UNIT_W-1:0]        csr_wr_data = '0;

   position_scoreboard sb;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned beats_sent = 0;
   bit          long_hold_pending = 1'b0;

   text_position_tracker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // data_byte
      .req_tlast   (req_tlast),    // end_of_text
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // byte_offset, line_number, line_bytes, char_column
      .rsp_tuser   (rsp_tuser),    // at_boundary
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)   // unit_encoding
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // result side: check accepted beats, then pick the next ready
   initial begin : rsp_side
      int unsigned hold_cnt;
      hold_cnt = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            hold_cnt = 64;
         end
         if (hold_cnt != 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic eot);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= eot;
      do @(posedge clock); while (!req_tready);
      sb.note_input(b, eot);
      beats_sent++;
   endtask

   function automatic logic [7:0] cont_byte();
      return 8'($urandom_range(8'hBF, 8'h80));
   endfunction

   function automatic logic [7:0] lead_byte(int unsigned len);
      case (len)
         2: return 8'($urandom_range(8'hDF, 8'hC0));
         3: return 8'($urandom_range(8'hEF, 8'hE0));
         default: return 8'($urandom_range(8'hF7, 8'hF0));
      endcase
   endfunction

   task automatic send_random_char();
      int unsigned pick, len;
      pick = $urandom_range(99);
      if (pick < 35) begin
         send_beat(8'($urandom_range(8'h7F)), 1'b0);
      end else if (pick < 43) begin
         send_beat(tpt_pkg::NEWLINE, 1'b0);
      end else if (pick < 77) begin
         len = (pick < 55) ? 2 : (pick < 67) ? 3 : 4;
         send_beat(lead_byte(len), 1'b0);
         repeat (len - 1) send_beat(cont_byte(), 1'b0);
      end else if (pick < 87) begin
         // truncated sequence, the next character fills the tail
         len = $urandom_range(4, 2);
         send_beat(lead_byte(len), 1'b0);
         repeat ($urandom_range(len - 2)) send_beat(cont_byte(), 1'b0);
      end else if (pick < 92) begin
         send_beat(8'($urandom_range(8'hFF)), 1'b0);
      end else if (pick < 95) begin
         send_beat(lead_byte($urandom_range(4, 2)), 1'b0);
         send_beat(tpt_pkg::NEWLINE, 1'b0);
      end else if (pick < 97) begin
         send_beat(8'($urandom_range(8'hFF)), 1'b1);
      end else begin
         send_beat(8'($urandom_range(8'hFF, 8'hF8)), 1'b0);
      end
   endtask

   task automatic stop_and_drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_unit(input logic [tpt_pkg::UNIT_W-1:0] u);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= u;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_unit(u);
   endtask

   task automatic run_random(input int unsigned req_pct, input int unsigned rsp_pct,
                             input logic [tpt_pkg::UNIT_W-1:0] u, input int unsigned n,
                             input bit long_hold);
      int unsigned target;
      stop_and_drain();
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      write_unit(u);
      if (long_hold) long_hold_pending = 1'b1;
      target = beats_sent + n;
      while (beats_sent < target) send_random_char();
   endtask

   // bit 8 marks an end of text beat
   logic [8:0] directed_beats[] = '{
      9'h041, 9'h000, 9'h0FF, 9'h080, 9'h0F8,
      9'h0C3, 9'h0A9,
      9'h0E2, 9'h082, 9'h0AC,
      9'h0F0, 9'h09F, 9'h098, 9'h080,
      9'h0E2, 9'h00A,
      9'h0F4, 9'h041, 9'h042, 9'h043,
      9'h07F, 9'h00A,
      9'h1FF, 9'h0C2, 9'h100, 9'h00A
   };

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_beats[i]) send_beat(directed_beats[i][7:0], directed_beats[i][8]);

      run_random(8, 53, tpt_pkg::UNIT_UTF8, 440, 1'b0);
      run_random(53, 8, tpt_pkg::UNIT_CODEPOINT, 440, 1'b0);
      run_random(0, 0, UNIT_SPARE, 220, 1'b1);
      run_random(0, 0, tpt_pkg::UNIT_UTF16, 220, 1'b0);

      stop_and_drain();
      repeat (4) @(posedge clock);
      sb.close_out();
      $display("covered %0d document bytes and %0d end markers over all four column units",
               sb.bytes_seen, sb.ends_seen);
      $display("%0d result beats checked under sender and receiver stalls, %0d failures",
               sb.results_checked, sb.failures);
      if (sb.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
